// ===== src/rqs_pkg.sv =====
`default_nettype none

package rqs_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam int PID_W      = 4;
  localparam int BURST_W    = 16;
  localparam int MODE_W     = 2;
  localparam int QUANT_W    = 9;
  localparam int OCC_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [QUANT_W-1:0] QUANT_RESET = 9'd100;

  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RR   = 2'd2;

  localparam logic KIND_ENQUEUE  = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED   = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic               kind;
    logic [PID_W-1:0]   process_id;
    logic [BURST_W-1:0] burst_ms;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [PID_W-1:0]   granted_pid;
    logic [BURST_W-1:0] granted_time;
    logic               burst_done;
    logic [OCC_W-1:0]   occupancy;
  } res_t;

endpackage

`default_nettype wire

// ===== src/ready_queue_fcfs_sjf_rr_unit.sv =====
`default_nettype none

// channel   signals                                   handshake
// request   start, cmd                                taken when start && !busy
// result    res, res_valid                            one-cycle strobe, no stall
// config    cfg_valid, cfg_index, cfg_data, cfg_ready taken when cfg_valid && cfg_ready
//
// enqueue and dispatch on an empty queue: result in the cycle after the request, busy stays low
// fcfs and rr dispatch: one read of the head slot through the queue memory, busy in state head
// sjf dispatch: a scan of every queued entry, then, unless the tail entry is picked, a shift to close the gap
//   behind the picked slot; both go through the single read port of the queue memory
// synchronous reset empties the queue and loads mode fcfs, quantum 100; no clearing pass
// results cannot be stalled; config is always ready

module ready_queue_fcfs_sjf_rr_unit #(
  parameter int QUEUE_DEPTH = rqs_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire rqs_pkg::cmd_t                   cmd,
  output rqs_pkg::res_t                        res,
  output logic                                 res_valid,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rqs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rqs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = PTR_W + 1;
  localparam int PID_W   = rqs_pkg::PID_W;
  localparam int BURST_W = rqs_pkg::BURST_W;
  localparam int MODE_W  = rqs_pkg::MODE_W;
  localparam int QUANT_W = rqs_pkg::QUANT_W;
  localparam int OCC_W   = rqs_pkg::OCC_W;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] burst;
  } entry_t;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // queue memory, ring ordered from head
  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  logic [PTR_W-1:0] rd_addr;
  logic             we;
  logic [PTR_W-1:0] wr_addr;
  entry_t           wr_data;

  rqs_pkg::state_t state, state_next;
  logic [PTR_W-1:0]   head, head_next;
  logic [PTR_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   issue_off, issue_off_next;
  logic [CNT_W-1:0]   data_off, data_off_next;
  logic               data_vld, data_vld_next;
  logic [CNT_W-1:0]   best_off, best_off_next;
  logic [PID_W-1:0]   best_pid, best_pid_next;
  logic [BURST_W-1:0] best_burst, best_burst_next;
  logic [MODE_W-1:0]  mode;
  logic [QUANT_W-1:0] quantum;
  rqs_pkg::res_t      res_next;
  logic               res_valid_next;

  logic               accept;
  logic [CNT_W-1:0]   last_off;
  logic               is_full;
  logic               last_data;

  assign busy      = (state != rqs_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign last_off  = count - CNT_W'(1);
  assign is_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign last_data = data_vld && (data_off == last_off);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // running minimum, earliest entry wins a tie
  always_comb begin
    best_off_next   = best_off;
    best_pid_next   = best_pid;
    best_burst_next = best_burst;
    if (state == rqs_pkg::S_SCAN && data_vld &&
        (data_off == '0 || rd_data.burst < best_burst)) begin
      best_off_next   = data_off;
      best_pid_next   = rd_data.pid;
      best_burst_next = rd_data.burst;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rqs_pkg::S_IDLE: begin
        if (accept && cmd.kind == rqs_pkg::KIND_DISPATCH && count != '0) begin
          state_next = (mode == rqs_pkg::MODE_SJF) ? rqs_pkg::S_SCAN : rqs_pkg::S_HEAD;
        end
      end
      rqs_pkg::S_HEAD: state_next = rqs_pkg::S_IDLE;
      rqs_pkg::S_SCAN: begin
        if (last_data) begin
          state_next = (best_off_next == last_off) ? rqs_pkg::S_IDLE : rqs_pkg::S_SHIFT;
        end
      end
      rqs_pkg::S_SHIFT: begin
        if (last_data) begin
          state_next = rqs_pkg::S_IDLE;
        end
      end
      default: state_next = rqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    issue_off_next = issue_off;
    data_off_next  = data_off;
    data_vld_next  = data_vld;
    we             = 1'b0;
    wr_addr        = tail;
    wr_data        = '{pid: cmd.process_id, burst: cmd.burst_ms};
    rd_addr        = (state == rqs_pkg::S_IDLE) ? head : wrap_add(head, issue_off);
    res_next       = '0;
    res_valid_next = 1'b0;

    unique case (state)
      rqs_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd.kind == rqs_pkg::KIND_ENQUEUE) begin
            res_valid_next = 1'b1;
            if (is_full) begin
              res_next.status    = rqs_pkg::ST_FULL;
              res_next.occupancy = OCC_W'(count);
            end else begin
              we                 = 1'b1;
              tail_next          = wrap_add(tail, CNT_W'(1));
              count_next         = count + CNT_W'(1);
              res_next.status    = rqs_pkg::ST_ENQUEUED;
              res_next.occupancy = OCC_W'(count + CNT_W'(1));
            end
          end else if (count == '0) begin
            res_valid_next     = 1'b1;
            res_next.status    = rqs_pkg::ST_EMPTY;
            res_next.occupancy = OCC_W'(count);
          end else if (mode == rqs_pkg::MODE_SJF) begin
            // head slot is read this cycle as offset zero
            issue_off_next = CNT_W'(1);
            data_off_next  = '0;
            data_vld_next  = 1'b1;
          end
        end
      end

      rqs_pkg::S_HEAD: begin
        head_next            = wrap_add(head, CNT_W'(1));
        res_valid_next       = 1'b1;
        res_next.status      = rqs_pkg::ST_DISPATCHED;
        res_next.granted_pid = rd_data.pid;
        if (mode == rqs_pkg::MODE_RR && rd_data.burst > BURST_W'(quantum)) begin
          // slice used up, remainder goes back to the tail
          we                    = 1'b1;
          wr_data               = '{pid: rd_data.pid,
                                    burst: rd_data.burst - BURST_W'(quantum)};
          tail_next             = wrap_add(tail, CNT_W'(1));
          res_next.granted_time = BURST_W'(quantum);
          res_next.burst_done   = 1'b0;
          res_next.occupancy    = OCC_W'(count);
        end else begin
          count_next            = count - CNT_W'(1);
          res_next.granted_time = rd_data.burst;
          res_next.burst_done   = 1'b1;
          res_next.occupancy    = OCC_W'(count - CNT_W'(1));
        end
      end

      rqs_pkg::S_SCAN: begin
        if (last_data) begin
          data_vld_next = 1'b0;
          if (best_off_next == last_off) begin
            // picked the tail entry, nothing to close up
            tail_next             = wrap_add(tail, CNT_W'(QUEUE_DEPTH - 1));
            count_next            = last_off;
            res_valid_next        = 1'b1;
            res_next.status       = rqs_pkg::ST_DISPATCHED;
            res_next.granted_pid  = best_pid_next;
            res_next.granted_time = best_burst_next;
            res_next.burst_done   = 1'b1;
            res_next.occupancy    = OCC_W'(last_off);
          end else begin
            issue_off_next = best_off_next + CNT_W'(1);
          end
        end else if (issue_off < count) begin
          issue_off_next = issue_off + CNT_W'(1);
          data_off_next  = issue_off;
          data_vld_next  = 1'b1;
        end else begin
          data_vld_next = 1'b0;
        end
      end

      rqs_pkg::S_SHIFT: begin
        // entry read last cycle moves one slot toward the head
        if (data_vld) begin
          we      = 1'b1;
          wr_addr = wrap_add(head, data_off - CNT_W'(1));
          wr_data = rd_data;
        end
        if (last_data) begin
          data_vld_next         = 1'b0;
          tail_next             = wrap_add(tail, CNT_W'(QUEUE_DEPTH - 1));
          count_next            = last_off;
          res_valid_next        = 1'b1;
          res_next.status       = rqs_pkg::ST_DISPATCHED;
          res_next.granted_pid  = best_pid;
          res_next.granted_time = best_burst;
          res_next.burst_done   = 1'b1;
          res_next.occupancy    = OCC_W'(last_off);
        end else if (issue_off < count) begin
          issue_off_next = issue_off + CNT_W'(1);
          data_off_next  = issue_off;
          data_vld_next  = 1'b1;
        end else begin
          data_vld_next = 1'b0;
        end
      end

      default: begin
        data_vld_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rqs_pkg::S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      data_vld  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      data_vld  <= data_vld_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    issue_off  <= issue_off_next;
    data_off   <= data_off_next;
    best_off   <= best_off_next;
    best_pid   <= best_pid_next;
    best_burst <= best_burst_next;
    res        <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= rqs_pkg::MODE_FCFS;
      quantum <= rqs_pkg::QUANT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rqs_pkg::CFG_MODE:    mode    <= cfg_data[MODE_W-1:0];
        rqs_pkg::CFG_QUANTUM: quantum <= cfg_data[QUANT_W-1:0];
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    (state == rqs_pkg::S_IDLE) |-> (tail == wrap_add(head, count)))
    else $error("tail does not match head plus count");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == rqs_pkg::S_IDLE))
    else $error("result strobe while a dispatch is in progress");

  a_enqueue_count: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == rqs_pkg::KIND_ENQUEUE && !is_full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("enqueue did not grow the queue");

  a_dispatch_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == rqs_pkg::KIND_DISPATCH && count != '0) |=> busy)
    else $error("dispatch on a held entry did not go busy");

endmodule

`default_nettype wire
